// File: src/hsdm_pkg.sv
// Package for the stereo delay mixer: register indexes, Q1.15 constants
// and the per-item control word passed between pipeline stages.
// No dependencies.
`default_nettype none

package hsdm_pkg;

	localparam int CFG_BITS = 16;
	localparam int FRAC_BITS = 15;
	localparam int ROUND_HALF = 16384;
	localparam logic [CFG_BITS-1:0] Q_ONE = 16'h8000;

	localparam logic [1:0] REG_DELAY_LENGTH = 2'd0;
	localparam logic [1:0] REG_MIX_GAIN = 2'd1;
	localparam logic [1:0] REG_LEFT_SOURCE = 2'd2;

	typedef struct packed {
		logic valid;
		logic active;
		logic delv;
		logic sel;
		logic last;
	} hsdm_ctrl_t;

endpackage

`default_nettype wire

// File: src/hsdm_delay_ram.sv
// Single-port delay line RAM, read-first, with registered read data.
// No dependencies.
`default_nettype none

module hsdm_delay_ram #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 24
) (
	input  wire                     clk,
	input  wire                     rd_en,
	input  wire                     wr_en,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read and write share one address; the read returns the old content.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[addr];
		end
		if (wr_en) begin
			mem[addr] <= wdata;
		end
	end

endmodule

`default_nettype wire

// File: src/hsdm_mix_dp.sv
// Mixing datapath: weight products, rounded sum and output register.
// Depends on hsdm_pkg.
`default_nettype none

module hsdm_mix_dp import hsdm_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  hsdm_ctrl_t                   ctrl_s1,
	input  wire signed [SAMPLE_BITS-1:0] left_s1,
	input  wire signed [SAMPLE_BITS-1:0] right_s1,
	input  wire signed [SAMPLE_BITS-1:0] del_rdata,
	input  wire [CFG_BITS-1:0]           mix,
	output logic                         adv,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [SAMPLE_BITS-1:0]       left_out,
	output logic [SAMPLE_BITS-1:0]       right_out,
	output logic                         last_out
);

	localparam int PW = SAMPLE_BITS + 18;

	hsdm_ctrl_t ctrl_s2;
	logic signed [SAMPLE_BITS-1:0] left_s2, right_s2;
	logic signed [PW-1:0] prod_dry_s2, prod_del_s2;

	logic signed [SAMPLE_BITS-1:0] dry, del;
	logic signed [PW-1:0] dry_x, del_x, wdry_x, wdel_x, sum, shifted;
	logic [CFG_BITS:0] w_dry;
	logic signed [SAMPLE_BITS-1:0] wet;

	logic valid_q, last_q;
	logic [SAMPLE_BITS-1:0] left_q, right_q;

	assign adv = !valid_q || out_ready;

	always_comb begin
		dry = ctrl_s1.sel ? right_s1 : left_s1;
		del = ctrl_s1.delv ? del_rdata : '0;
		w_dry = (CFG_BITS+1)'({1'b0, Q_ONE}) - (CFG_BITS+1)'({1'b0, mix});
		dry_x = PW'(dry);
		del_x = PW'(del);
		wdry_x = $signed(PW'(w_dry));
		wdel_x = $signed(PW'(mix));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (adv) begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_s2 <= left_s1;
			right_s2 <= right_s1;
			prod_dry_s2 <= dry_x * wdry_x;
			prod_del_s2 <= del_x * wdel_x;
		end
	end

	// Arithmetic shift of the biased sum is the floor of the Q1.15 value.
	always_comb begin
		sum = prod_dry_s2 + prod_del_s2 + PW'(ROUND_HALF);
		shifted = sum >>> FRAC_BITS;
		wet = shifted[SAMPLE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= ctrl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_q <= ctrl_s2.last;
			left_q <= (ctrl_s2.active && !ctrl_s2.sel) ? wet : left_s2;
			right_q <= (ctrl_s2.active && ctrl_s2.sel) ? wet : right_s2;
		end
	end

	assign out_valid = valid_q;
	assign left_out = left_q;
	assign right_out = right_q;
	assign last_out = last_q;

endmodule

`default_nettype wire

// File: src/haas_stereo_delay_mixer.sv
// Top level of the Haas stereo delay mixer: configuration registers,
// delay line addressing and pipeline. Depends on hsdm_pkg, hsdm_delay_ram
// and hsdm_mix_dp.
`default_nettype none

// Usage
// The slave stream (s_*) takes one stereo pair per item: s_tdata holds the
// left sample in the low bits and the right sample above it, s_tlast marks
// the last pair of a processing block. The master stream (m_*) returns one
// processed pair per item in the same layout, with m_tlast copied through.
// The source channel is written into a circular delay line held in one
// single-port RAM; the other channel becomes dry*(1-mix) + delayed*mix.
// The accepting edge captures the RAM read data in stage 1, stage 2
// registers the two weight products, and the output register then loads
// the rounded sum and raises m_tvalid. Throughput is one item per cycle
// while the output register is empty or m_tready is high; the RAM is read
// and written at the same address in the acceptance cycle, so no interlock
// is needed even at a delay of one sample.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops in the same cycle; it follows m_tready while the
// output register is full. Reset clears the registers (the left channel is
// the source) and the fill counter, so the RAM needs no clearing pass;
// writing delay_length clears the line the same way. The APB port is
// always ready.

module haas_stereo_delay_mixer import hsdm_pkg::*; #(
	parameter int MAX_DELAY = 65536,
	parameter int SAMPLE_BITS = 24
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	// APB configuration port
	input  wire                                      psel,
	input  wire                                      penable,
	input  wire                                      pwrite,
	input  wire [3:0]                                paddr,
	input  wire [31:0]                               pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready,
	// Input stream
	input  wire                                      s_tvalid,
	output logic                                     s_tready,
	// s_tdata fields from bit 0: left_in, right_in, zero pad
	input  wire [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
	input  wire                                      s_tlast,
	// Output stream
	output logic                                     m_tvalid,
	input  wire                                      m_tready,
	// m_tdata fields from bit 0: left_out, right_out, zero pad
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,
	output logic                                     m_tlast
);

	localparam int AW = $clog2(MAX_DELAY);
	localparam int LW = (AW + 1 > CFG_BITS + 1) ? AW + 1 : CFG_BITS + 1;
	localparam int DW = ((2*SAMPLE_BITS+7)/8)*8;

	logic [CFG_BITS-1:0] delay_length_q, mix_gain_q;
	logic left_src_q;
	logic cfg_wr;
	logic [1:0] cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_length_q <= '0;
			mix_gain_q <= '0;
			left_src_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_DELAY_LENGTH: delay_length_q <= pwdata[CFG_BITS-1:0];
				REG_MIX_GAIN: mix_gain_q <= pwdata[CFG_BITS-1:0];
				REG_LEFT_SOURCE: left_src_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_DELAY_LENGTH: prdata = 32'(delay_length_q);
			REG_MIX_GAIN: prdata = 32'(mix_gain_q);
			REG_LEFT_SOURCE: prdata = 32'(left_src_q);
			default: prdata = '0;
		endcase
	end

	// Effective length and mix, both saturated.
	logic [LW-1:0] len_ext, len_eff;
	logic [CFG_BITS-1:0] mix_sat;
	logic active;

	always_comb begin
		len_ext = LW'(delay_length_q);
		len_eff = (len_ext > LW'(MAX_DELAY)) ? LW'(MAX_DELAY) : len_ext;
		mix_sat = (mix_gain_q > Q_ONE) ? Q_ONE : mix_gain_q;
		active = (len_eff != '0) && (mix_sat != '0);
	end

	// Delay line addressing. The fill counter makes entries that were not
	// written since the last clear read as zero.
	logic [AW-1:0] wp_q, wp_cur, wp_next;
	logic [LW-1:0] fill_q, wp_inc;
	logic delv, accept, wr_en, adv;
	logic signed [SAMPLE_BITS-1:0] left_in, right_in, src, del_rdata;

	assign left_in = s_tdata[SAMPLE_BITS-1:0];
	assign right_in = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign s_tready = adv;
	assign accept = s_tvalid && s_tready;
	assign wr_en = accept && active;
	assign src = left_src_q ? left_in : right_in;

	always_comb begin
		wp_cur = (LW'(wp_q) >= len_eff) ? '0 : wp_q;
		wp_inc = LW'(wp_cur) + LW'(1);
		wp_next = (wp_inc >= len_eff) ? '0 : wp_inc[AW-1:0];
		delv = fill_q >= len_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			fill_q <= '0;
		end else if (cfg_wr && cfg_idx == REG_DELAY_LENGTH) begin
			wp_q <= '0;
			fill_q <= '0;
		end else if (wr_en) begin
			wp_q <= wp_next;
			if (fill_q < len_eff) begin
				fill_q <= fill_q + LW'(1);
			end
		end
	end

	hsdm_delay_ram #(
		.DEPTH(MAX_DELAY),
		.WIDTH(SAMPLE_BITS)
	) u_ram (
		.clk(clk),
		.rd_en(adv),
		.wr_en(wr_en),
		.addr(wp_cur),
		.wdata(src),
		.rdata(del_rdata)
	);

	// Stage 1 lines up with the RAM read data.
	hsdm_ctrl_t ctrl_s1;
	logic signed [SAMPLE_BITS-1:0] left_s1, right_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (adv) begin
			ctrl_s1.valid <= accept;
			ctrl_s1.active <= active;
			ctrl_s1.delv <= delv;
			ctrl_s1.sel <= left_src_q;
			ctrl_s1.last <= s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_s1 <= left_in;
			right_s1 <= right_in;
		end
	end

	logic [SAMPLE_BITS-1:0] left_out, right_out;

	hsdm_mix_dp #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mix (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl_s1(ctrl_s1),
		.left_s1(left_s1),
		.right_s1(right_s1),
		.del_rdata(del_rdata),
		.mix(mix_sat),
		.adv(adv),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.left_out(left_out),
		.right_out(right_out),
		.last_out(m_tlast)
	);

	assign m_tdata = DW'({right_out, left_out});

endmodule

`default_nettype wire

// File: bench/haas_stereo_delay_mixer_test.sv
// Self-checking testbench for haas_stereo_delay_mixer: streams stereo pairs through the
// block and compares every output pair with an in-bench model of the delay line and mixer.
// Depends on hsdm_pkg and the haas_stereo_delay_mixer RTL.
`timescale 1ns / 1ps

module haas_stereo_delay_mixer_test import hsdm_pkg::*;;

	localparam int SAMPLE_BITS = 24;
	localparam int LINE_DEPTH = 65536;
	localparam int DRAIN_CYCLES = 6;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 90;
	localparam logic [3:0] UNMAPPED_ADDR = 4'hC;
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

	// One stereo pair plus its block marker, used for both inputs and expected outputs.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] right;
		logic signed [SAMPLE_BITS-1:0] left;
		logic last;
	} stereo_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// s_tdata fields from bit 0: left_in, right_in
	logic [2*SAMPLE_BITS-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// m_tdata fields from bit 0: left_out, right_out
	logic [2*SAMPLE_BITS-1:0] m_tdata;
	logic m_tlast;

	haas_stereo_delay_mixer #(
		.MAX_DELAY(LINE_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #10 clk = ~clk;

	// Mirror of the block's registers and delay line. The line is indexed the same way as
	// the hardware: a write pointer that wraps at the delay length and a fill count that
	// makes entries not yet written since the last clear read as silence.
	logic [15:0] cfg_length = 16'd0;
	logic [15:0] cfg_mix = 16'd0;
	logic cfg_right = 1'b1;
	logic signed [SAMPLE_BITS-1:0] echo_line [LINE_DEPTH];
	int unsigned echo_wp = 0;
	int unsigned echo_fill = 0;

	stereo_pair_t pending_pairs[$];
	int mismatches = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	// Expected output for one accepted pair; advances the mirrored delay line.
	function automatic stereo_pair_t mix_pair(stereo_pair_t dry_in);
		stereo_pair_t res;
		longint src;
		longint dry;
		longint del;
		longint wgt;
		longint acc;
		longint wet;
		res = dry_in;
		wgt = (cfg_mix > Q_ONE) ? longint'(Q_ONE) : longint'(cfg_mix);
		if (cfg_length != 0 && wgt != 0) begin
			src = cfg_right ? dry_in.left : dry_in.right;
			dry = cfg_right ? dry_in.right : dry_in.left;
			if (echo_wp >= cfg_length)
				echo_wp = 0;
			if (echo_fill >= cfg_length)
				del = echo_line[echo_wp];
			else
				del = 0;
			echo_line[echo_wp] = src[SAMPLE_BITS-1:0];
			echo_wp++;
			if (echo_wp >= cfg_length)
				echo_wp = 0;
			if (echo_fill < cfg_length)
				echo_fill++;
			// Weighted sum in Q1.15; the arithmetic shift is a floor, so adding one half
			// first rounds to nearest with ties toward plus infinity.
			acc = dry * (longint'(Q_ONE) - wgt) + del * wgt + ROUND_HALF;
			wet = acc >>> FRAC_BITS;
			if (cfg_right)
				res.right = wet[SAMPLE_BITS-1:0];
			else
				res.left = wet[SAMPLE_BITS-1:0];
		end
		return res;
	endfunction

	// Full-scale values, values near zero and uniform noise, so every sample bit toggles.
	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return SAMPLE_BITS'($signed($urandom_range(0, 8)) - 4);
			default: return r[SAMPLE_BITS-1:0];
		endcase
	endfunction

	// Receiver: m_tready changes only at the falling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Result checker: every accepted output pair is matched against the oldest expectation.
	always @(posedge clk) begin
		stereo_pair_t exp_pair;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pairs.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected output pair, expected none, actual %h last %b",
					$time, m_tdata, m_tlast);
			end else begin
				exp_pair = pending_pairs.pop_front();
				if (m_tdata[SAMPLE_BITS-1:0] !== exp_pair.left) begin
					mismatches++;
					$display("%0t: left_out expected %h actual %h", $time, exp_pair.left,
						m_tdata[SAMPLE_BITS-1:0]);
				end
				if (m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== exp_pair.right) begin
					mismatches++;
					$display("%0t: right_out expected %h actual %h", $time, exp_pair.right,
						m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
				end
				if (m_tlast !== exp_pair.last) begin
					mismatches++;
					$display("%0t: block_end expected %b actual %b", $time, exp_pair.last,
						m_tlast);
				end
			end
		end
	end

	// Watchdog over the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles, %0d pairs still expected", $time,
				CYCLE_LIMIT, pending_pairs.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Sends one pair. Idle cycles are inserted first; valid stays high until accepted, and
	// the expectation is computed at the accepting edge.
	task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] l,
			input logic signed [SAMPLE_BITS-1:0] r, input logic last);
		stereo_pair_t item;
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {r, l};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		item.left = l;
		item.right = r;
		item.last = last;
		pending_pairs.push_back(mix_pair(item));
	endtask

	// Lowers valid and waits until the pipeline is empty, so registers may be written.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One APB transfer: setup cycle, access cycle, then the bus goes idle.
	task automatic apb_access(input logic wr, input logic [3:0] addr, input logic [31:0] data,
			output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] unused;
		apb_access(1'b1, {idx, 2'b00}, value, unused);
		case (idx)
			REG_DELAY_LENGTH: begin
				// Any write of the length clears the line, even with the same value.
				cfg_length = value[15:0];
				echo_wp = 0;
				echo_fill = 0;
			end
			REG_MIX_GAIN: cfg_mix = value[15:0];
			REG_LEFT_SOURCE: cfg_right = value[0];
			default: ;
		endcase
	endtask

	// Reads all three registers back and compares them with the mirrored values.
	task automatic check_regs();
		logic [31:0] got;
		apb_access(1'b0, {REG_DELAY_LENGTH, 2'b00}, 32'd0, got);
		if (got !== {16'd0, cfg_length}) begin
			mismatches++;
			$display("%0t: delay_length read expected %h actual %h", $time, cfg_length, got);
		end
		apb_access(1'b0, {REG_MIX_GAIN, 2'b00}, 32'd0, got);
		if (got !== {16'd0, cfg_mix}) begin
			mismatches++;
			$display("%0t: mix_gain read expected %h actual %h", $time, cfg_mix, got);
		end
		apb_access(1'b0, {REG_LEFT_SOURCE, 2'b00}, 32'd0, got);
		if (got !== {31'd0, cfg_right}) begin
			mismatches++;
			$display("%0t: source select read expected %h actual %h", $time, cfg_right, got);
		end
	endtask

	// Out of reset the length is zero, so pairs must pass through untouched.
	task automatic test_reset_state();
		check_regs();
		send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
		send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
		settle();
	endtask

	// A zero mix with a nonzero length is also a bypass and must not advance the line;
	// once the mix is raised the first reads come from a still empty line.
	task automatic test_zero_mix_bypass();
		write_reg(REG_DELAY_LENGTH, 32'd3);
		send_pair(24'sd1000, -24'sd1000, 1'b0);
		send_pair(24'sd77, 24'sd5, 1'b0);
		settle();
		write_reg(REG_MIX_GAIN, 32'd16384);
		send_pair(24'sd200, 24'sd3, 1'b0);
		send_pair(-24'sd9, 24'sd4, 1'b1);
		settle();
	endtask

	// A one-sample delay at full wet gain; mix values above one must saturate to one.
	task automatic test_unit_delay_full_wet();
		write_reg(REG_DELAY_LENGTH, 32'd1);
		write_reg(REG_MIX_GAIN, 32'hFFFF_FFFF);
		send_pair(SAMPLE_MAX, 24'sd0, 1'b0);
		send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
		send_pair(24'sd0, SAMPLE_MIN, 1'b0);
		settle();
		write_reg(REG_MIX_GAIN, {16'd0, Q_ONE});
		send_pair(24'sd12345, -24'sd1, 1'b1);
		settle();
	endtask

	// Right channel as the source, with half-way values that land on rounding ties.
	task automatic test_right_source_rounding();
		write_reg(REG_LEFT_SOURCE, 32'd0);
		write_reg(REG_DELAY_LENGTH, 32'd2);
		write_reg(REG_MIX_GAIN, 32'd16384);
		send_pair(24'sd0, 24'sd1, 1'b0);
		send_pair(24'sd0, -24'sd1, 1'b0);
		send_pair(24'sd0, 24'sd3, 1'b0);
		send_pair(-24'sd2, SAMPLE_MIN, 1'b1);
		settle();
	endtask

	// Rewriting the length with its current value must still clear the line.
	task automatic test_line_clear();
		write_reg(REG_DELAY_LENGTH, 32'd2);
		send_pair(24'sd500, 24'sd600, 1'b0);
		send_pair(24'sd700, 24'sd800, 1'b0);
		send_pair(24'sd900, SAMPLE_MAX, 1'b1);
		settle();
	endtask

	// A write to the address beyond the last register changes nothing.
	task automatic test_unmapped_write();
		logic [31:0] unused;
		apb_access(1'b1, UNMAPPED_ADDR, 32'hFFFF_FFFF, unused);
		check_regs();
		send_pair(24'sd31, -24'sd31, 1'b0);
		settle();
	endtask

	// The longest line only returns silence within a few items, but exercises the bound.
	task automatic test_longest_line();
		write_reg(REG_LEFT_SOURCE, 32'd1);
		write_reg(REG_DELAY_LENGTH, 32'd65535);
		write_reg(REG_MIX_GAIN, 32'd32767);
		send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
		send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
		settle();
	endtask

	// Random traffic in several register settings under one idling mode. The length is
	// mostly short so that the delayed path is read often; now and then the length is left
	// alone so that a line keeps running across a change of mix or direction.
	task automatic test_random_traffic(input int mode);
		int phase;
		int n;
		logic [31:0] len_val;
		logic [31:0] mix_val;
		case (mode)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 88; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 88; end
			default: begin idle_pct = 27; stall_pct = 27; end
		endcase
		for (phase = 0; phase < 4; phase++) begin
			settle();
			case ($urandom_range(0, 15))
				0: len_val = 32'd0;
				1: len_val = 32'd65535;
				2: len_val = $urandom_range(1000, 65534);
				default: len_val = $urandom_range(1, 24);
			endcase
			case ($urandom_range(0, 9))
				0: mix_val = 32'd0;
				1: mix_val = {16'd0, Q_ONE};
				2: mix_val = $urandom_range(32769, 65535);
				3: mix_val = 32'd1;
				default: mix_val = $urandom_range(1, 32767);
			endcase
			if (phase == 0 || $urandom_range(0, 3) != 0)
				write_reg(REG_DELAY_LENGTH, len_val);
			write_reg(REG_MIX_GAIN, mix_val);
			write_reg(REG_LEFT_SOURCE, $urandom);
			check_regs();
			for (n = 0; n < PHASE_ITEMS; n++) begin
				send_pair(rand_sample(), rand_sample(), ($urandom_range(0, 7) == 0));
				// Once in a while hold the sender until all results are back.
				if (n == PHASE_ITEMS / 2 && phase == mode)
					settle();
				// Stretches without any idling inside every mode but mode 0.
				if (mode != 0 && n == 10)
					idle_pct = 0;
				if (mode == 1 && n == 30)
					idle_pct = 88;
				if (mode == 3 && n == 30)
					idle_pct = 27;
			end
		end
	endtask

	initial begin
		int mode;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_zero_mix_bypass();
		test_unit_delay_full_wet();
		test_right_source_rounding();
		test_line_clear();
		test_unmapped_write();
		test_longest_line();
		for (mode = 0; mode < 4; mode++)
			test_random_traffic(mode);

		settle();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: files.f
src/hsdm_pkg.sv
src/hsdm_delay_ram.sv
src/hsdm_mix_dp.sv
src/haas_stereo_delay_mixer.sv
bench/haas_stereo_delay_mixer_test.sv
